### hdl/sbi_pkg.sv
// Package for the segment/box intersection block.
// Holds the coordinate width and the derived datapath types; no dependencies.
`timescale 1ns / 1ps
package sbi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int NUM_WIDTH   = COORD_WIDTH + 2;
    localparam int PROD_WIDTH  = 2 * NUM_WIDTH;
    localparam int NUM_AXES    = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [NUM_WIDTH-1:0]   t_num;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;

endpackage

### hdl/segment_box_intersect_top.sv
// Liang-Barsky test of a 2-D segment against an axis-aligned box.
// Depends on sbi_pkg for widths and datapath types.
//
// Usage:
//   A request is taken at each rising edge with start high and busy low.
//   busy is tied low: a new request may be issued in every cycle.
//   Each request yields exactly one result, o_hit, shown for one cycle
//   with o_valid high. Results leave in request order.
//   Throughput is one request per cycle.
//   Pipeline: stage 1 forms direction and slab offsets, stage 2 orders
//   the slab parameters, stage 3 holds the cross products (one signed
//   multiplier per product), stage 4 the final compare.
//   Touching the box counts as a hit. A zero direction on an axis makes
//   that axis a plain inclusive range test on the start point.
//   Reset (synchronous, active low) clears all stage valid bits; no
//   result appears until requests arrive again. The receiver cannot
//   stall, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps
module segment_box_intersect_top
    import sbi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    input  t_coord i_box_min_x,
    input  t_coord i_box_min_y,
    input  t_coord i_box_max_x,
    input  t_coord i_box_max_y,
    output logic   o_valid,
    output logic   o_hit
);

    t_coord s_s  [NUM_AXES];
    t_coord s_e  [NUM_AXES];
    t_coord s_mn [NUM_AXES];
    t_coord s_mx [NUM_AXES];

    logic  r1_vld, r2_vld, r3_vld, r4_vld;
    t_diff r1_d  [NUM_AXES];
    t_diff r1_na [NUM_AXES];
    t_diff r1_nb [NUM_AXES];
    logic  r1_in [NUM_AXES];
    t_diff n1_d  [NUM_AXES];
    t_diff n1_na [NUM_AXES];
    t_diff n1_nb [NUM_AXES];
    logic  n1_in [NUM_AXES];

    t_num r2_lo  [NUM_AXES];
    t_num r2_hi  [NUM_AXES];
    t_num r2_den [NUM_AXES];
    logic r2_pm  [NUM_AXES];
    t_num n2_lo  [NUM_AXES];
    t_num n2_hi  [NUM_AXES];
    t_num n2_den [NUM_AXES];
    logic n2_pm  [NUM_AXES];

    t_prod r3_p1, r3_p2, r3_p3, r3_p4;
    logic  r3_miss;
    t_prod n3_p1, n3_p2, n3_p3, n3_p4;
    logic  n3_miss;

    logic r4_hit;
    logic n4_hit;

    assign busy = 1'b0;

    always_comb begin
        s_s[0]  = i_start_x;
        s_s[1]  = i_start_y;
        s_e[0]  = i_end_x;
        s_e[1]  = i_end_y;
        s_mn[0] = i_box_min_x;
        s_mn[1] = i_box_min_y;
        s_mx[0] = i_box_max_x;
        s_mx[1] = i_box_max_y;
    end

    // stage 1: direction, slab offsets, inclusive range test of start
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n1_d[k]  = $signed({s_e[k][COORD_WIDTH-1], s_e[k]})
                     - $signed({s_s[k][COORD_WIDTH-1], s_s[k]});
            n1_na[k] = $signed({s_mn[k][COORD_WIDTH-1], s_mn[k]})
                     - $signed({s_s[k][COORD_WIDTH-1], s_s[k]});
            n1_nb[k] = $signed({s_mx[k][COORD_WIDTH-1], s_mx[k]})
                     - $signed({s_s[k][COORD_WIDTH-1], s_s[k]});
            n1_in[k] = (s_s[k] >= s_mn[k]) && (s_s[k] <= s_mx[k]);
        end
    end

    // stage 2: flip to positive direction, order slab params, parallel case
    always_comb begin
        t_num a, b, dd;
        logic neg, par;
        for (int k = 0; k < NUM_AXES; k++) begin
            neg = r1_d[k][DIFF_WIDTH-1];
            par = (r1_d[k] == '0);
            a   = $signed({r1_na[k][DIFF_WIDTH-1], r1_na[k]});
            b   = $signed({r1_nb[k][DIFF_WIDTH-1], r1_nb[k]});
            dd  = $signed({r1_d[k][DIFF_WIDTH-1], r1_d[k]});
            if (neg) begin
                a  = -a;
                b  = -b;
                dd = -dd;
            end
            if (par) begin
                n2_lo[k]  = t_num'(0);
                n2_hi[k]  = t_num'(1);
                n2_den[k] = t_num'(1);
            end else begin
                n2_lo[k]  = (a < b) ? a : b;
                n2_hi[k]  = (a < b) ? b : a;
                n2_den[k] = dd;
            end
            n2_pm[k] = par && !r1_in[k];
        end
    end

    // stage 3: cross products between axes; checks against [0,1]
    always_comb begin
        n3_p1   = t_prod'(r2_lo[0]) * t_prod'(r2_den[1]);
        n3_p2   = t_prod'(r2_hi[1]) * t_prod'(r2_den[0]);
        n3_p3   = t_prod'(r2_lo[1]) * t_prod'(r2_den[0]);
        n3_p4   = t_prod'(r2_hi[0]) * t_prod'(r2_den[1]);
        n3_miss = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            if (r2_pm[k] || r2_hi[k][NUM_WIDTH-1] || (r2_lo[k] > r2_den[k])) begin
                n3_miss = 1'b1;
            end
        end
    end

    // stage 4: cross-axis interval overlap
    always_comb begin
        n4_hit = !r3_miss && !(r3_p1 > r3_p2) && !(r3_p3 > r3_p4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= start;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            r1_d[k]   <= n1_d[k];
            r1_na[k]  <= n1_na[k];
            r1_nb[k]  <= n1_nb[k];
            r1_in[k]  <= n1_in[k];
            r2_lo[k]  <= n2_lo[k];
            r2_hi[k]  <= n2_hi[k];
            r2_den[k] <= n2_den[k];
            r2_pm[k]  <= n2_pm[k];
        end
        r3_p1   <= n3_p1;
        r3_p2   <= n3_p2;
        r3_p3   <= n3_p3;
        r3_p4   <= n3_p4;
        r3_miss <= n3_miss;
        r4_hit  <= n4_hit;
    end

    assign o_valid = r4_vld;
    assign o_hit   = r4_hit;

endmodule
